// ----- hdl/stride_scheduler_table_defines.svh -----
// Assertion macros shared by the stride scheduler RTL.
`ifndef STRIDE_SCHEDULER_TABLE_DEFINES_SVH
`define STRIDE_SCHEDULER_TABLE_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define SST_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define SST_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- hdl/sst_pkg.sv -----
// Package with constants and helpers of the stride scheduler.
package sst_pkg;
    localparam int SLOTS_DEF = 64;
    localparam logic [31:0] BIG_STEP = 32'h7FFF_FFFF;
    localparam logic [9:0] MAX_SLICE_RST = 10'd5;

    localparam logic [1:0] CMD_ENQ = 2'd0;
    localparam logic [1:0] CMD_DEQ = 2'd1;
    localparam logic [1:0] CMD_PICK = 2'd2;
    localparam logic [1:0] CMD_TICK = 2'd3;

    // Wrap-safe compare: a precedes b when a - b is negative.
    function automatic logic stride_less(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return d[31];
    endfunction
endpackage

// ----- hdl/sst_ram.sv -----
// Generic single-port-write, single-read RAM with registered read data.
module sst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- hdl/sst_div.sv -----
// Iterative restoring divider computing 0x7FFFFFFF / priority, one bit per cycle.
module sst_div
    import sst_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_quot
);
    logic [31:0] r_rem;
    logic [31:0] r_quot;
    logic [31:0] r_div;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [32:0] n_trial;
    logic [31:0] n_rem_sh;

    assign n_rem_sh = {r_rem[30:0], r_quot[31]};
    assign n_trial  = {1'b0, n_rem_sh} - {1'b0, r_div};
    assign o_quot   = r_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd32;
                r_rem  <= '0;
                r_quot <= BIG_STEP;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                if (n_trial[32]) begin
                    r_rem  <= n_rem_sh;
                    r_quot <= {r_quot[30:0], 1'b0};
                end else begin
                    r_rem  <= n_trial[31:0];
                    r_quot <= {r_quot[30:0], 1'b1};
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
endmodule

// ----- hdl/stride_scheduler_table.sv -----
// Stride scheduler top level: command sequencer over the slot table memories.
// One transaction at a time. Enqueue, dequeue and tick read the slot's entries, then do the
// write-back and present the result. Pick reads every slot through the stride memory port,
// one slot per cycle. When a slot is queued it then reads that slot's priority and writes
// back the slot's new stride; a priority in 2 to 0x7FFFFFFF takes the shift-subtract divider
// for the stride step, the corner priorities do not. The next transaction is accepted only
// once the result has been taken. Queued bits sit in flip-flops cleared by reset. The stride,
// priority and slice memories are cleared after reset by a pass over every slot, and no
// transaction is accepted during that pass.
`include "stride_scheduler_table_defines.svh"
module stride_scheduler_table
    import sst_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [9:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: command[1:0], slot[7:2], task_priority[39:8], slice_request[49:40]
    input  logic [55:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: found[0], picked_slot[6:1], resched[7], queued_count[14:8], misuse[15]
    output logic [15:0] m_axis_tdata
);
    localparam int AW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RD, S_EXEC, S_SCAN, S_SCAN_LAST, S_PRD, S_PDIV,
        S_PWAIT, S_OUT
    } t_state;

    t_state          r_state;
    logic [9:0]      r_max_slice;
    logic [SLOTS-1:0] r_queued;
    logic [CW-1:0]   r_count;
    logic [AW:0]     r_idx;
    logic [1:0]      r_cmd;
    logic [5:0]      r_slot;
    logic [31:0]     r_prio;
    logic [9:0]      r_req;
    logic            r_found;
    logic [AW-1:0]   r_pick;
    logic [31:0]     r_best;
    logic [AW-1:0]   r_scan_addr;
    logic            r_scan_q;
    logic            r_resched;
    logic            r_misuse;
    logic            r_div_start;

    logic            w_ok;
    logic [AW-1:0]   w_sa;
    logic            st_we, pr_we, sl_we;
    logic [AW-1:0]   st_waddr, pr_waddr, sl_waddr, st_raddr, rd_addr;
    logic [31:0]     st_wdata, pr_wdata, st_rdata, pr_rdata;
    logic [9:0]      sl_wdata, sl_rdata, w_clamp;
    logic            div_done;
    logic [31:0]     div_quot;

    assign w_ok = ({26'd0, r_slot} < 32'(SLOTS));
    assign w_sa = AW'(r_slot) & {AW{w_ok}};
    assign w_clamp = (r_req == 10'd0 || r_req > r_max_slice) ? r_max_slice : r_req;

    sst_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_stride (
        .i_clk, .i_we(st_we), .i_waddr(st_waddr), .i_wdata(st_wdata),
        .i_raddr(st_raddr), .o_rdata(st_rdata));
    sst_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_prio (
        .i_clk, .i_we(pr_we), .i_waddr(pr_waddr), .i_wdata(pr_wdata),
        .i_raddr(rd_addr), .o_rdata(pr_rdata));
    sst_ram #(.WIDTH(10), .DEPTH(SLOTS)) u_slice (
        .i_clk, .i_we(sl_we), .i_waddr(sl_waddr), .i_wdata(sl_wdata),
        .i_raddr(rd_addr), .o_rdata(sl_rdata));
    sst_div u_div (
        .i_clk, .i_rst_n, .i_start(r_div_start), .i_divisor(pr_rdata),
        .o_done(div_done), .o_quot(div_quot));

    assign rd_addr  = (r_state == S_RD) ? w_sa : r_pick;
    assign st_raddr = (r_state == S_SCAN) ? r_idx[AW-1:0] : rd_addr;

    always_comb begin
        st_we = 1'b0; pr_we = 1'b0; sl_we = 1'b0;
        st_waddr = r_pick; pr_waddr = w_sa; sl_waddr = w_sa;
        st_wdata = '0; pr_wdata = r_prio; sl_wdata = w_clamp;
        case (r_state)
            S_CLEAR: begin
                st_we = 1'b1; pr_we = 1'b1; sl_we = 1'b1;
                st_waddr = r_idx[AW-1:0]; pr_waddr = r_idx[AW-1:0];
                sl_waddr = r_idx[AW-1:0];
                pr_wdata = '0; sl_wdata = '0;
            end
            S_EXEC: begin
                if (r_cmd == CMD_ENQ && w_ok && !r_queued[w_sa]) begin
                    pr_we = 1'b1; sl_we = 1'b1;
                end else if (r_cmd == CMD_TICK && w_ok && sl_rdata != 10'd0) begin
                    sl_we = 1'b1;
                    sl_wdata = sl_rdata - 10'd1;
                end
            end
            S_PDIV: begin
                // Step is known without division for the corner priorities.
                if (pr_rdata == 32'd0 || pr_rdata > BIG_STEP || pr_rdata == 32'd1) begin
                    st_we = 1'b1;
                    st_wdata = r_best + ((pr_rdata > BIG_STEP) ? 32'd1 : BIG_STEP);
                end
            end
            S_PWAIT: begin
                if (div_done) begin
                    st_we = 1'b1;
                    st_wdata = r_best + div_quot;
                end
            end
            default: ;
        endcase
    end

    assign s_axis_tready = (r_state == S_IDLE) && !m_axis_tvalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_idx       <= '0;
            r_max_slice <= MAX_SLICE_RST;
            r_queued    <= '0;
            r_count     <= '0;
            r_div_start <= 1'b0;
            m_axis_tvalid <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            if (i_cfg_we) begin
                r_max_slice <= i_cfg_wdata;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                m_axis_tvalid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == (AW+1)'(SLOTS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_cmd  <= s_axis_tdata[1:0];
                        r_slot <= s_axis_tdata[7:2];
                        r_prio <= s_axis_tdata[39:8];
                        r_req  <= s_axis_tdata[49:40];
                        r_found <= 1'b0; r_pick <= '0; r_resched <= 1'b0;
                        r_misuse <= 1'b0; r_idx <= '0;
                        r_state <= (s_axis_tdata[1:0] == CMD_PICK) ? S_SCAN : S_RD;
                    end
                end
                S_RD: r_state <= S_EXEC;
                S_EXEC: begin
                    case (r_cmd)
                        CMD_ENQ: begin
                            if (!w_ok || r_queued[w_sa]) begin
                                r_misuse <= 1'b1;
                            end else begin
                                r_queued[w_sa] <= 1'b1;
                                r_count <= r_count + 1'b1;
                            end
                        end
                        CMD_DEQ: begin
                            if (!w_ok || !r_queued[w_sa]) begin
                                r_misuse <= 1'b1;
                            end else begin
                                r_queued[w_sa] <= 1'b0;
                                r_count <= r_count - 1'b1;
                            end
                        end
                        default: begin
                            r_resched <= w_ok && (sl_rdata <= 10'd1);
                        end
                    endcase
                    r_state <= S_OUT;
                end
                S_SCAN: begin
                    // Stride of r_idx is read now; it is compared in the next cycle.
                    r_scan_addr <= r_idx[AW-1:0];
                    r_scan_q    <= r_queued[r_idx[AW-1:0]];
                    if (r_idx != '0 && r_scan_q &&
                        (!r_found || stride_less(st_rdata, r_best))) begin
                        r_found <= 1'b1; r_pick <= r_scan_addr; r_best <= st_rdata;
                    end
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == (AW+1)'(SLOTS - 1)) begin
                        r_state <= S_SCAN_LAST;
                    end
                end
                S_SCAN_LAST: begin
                    if (r_scan_q && (!r_found || stride_less(st_rdata, r_best))) begin
                        r_found <= 1'b1; r_pick <= r_scan_addr; r_best <= st_rdata;
                        r_state <= S_PRD;
                    end else begin
                        r_state <= r_found ? S_PRD : S_OUT;
                    end
                end
                S_PRD: r_state <= S_PDIV;
                S_PDIV: begin
                    if (pr_rdata == 32'd0 || pr_rdata > BIG_STEP || pr_rdata == 32'd1) begin
                        r_state <= S_OUT;
                    end else begin
                        r_div_start <= 1'b1;
                        r_state <= S_PWAIT;
                    end
                end
                S_PWAIT: begin
                    if (div_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    m_axis_tvalid <= 1'b1;
                    m_axis_tdata  <= {r_misuse, 7'(r_count), r_resched,
                                      6'(r_pick), r_found};
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `SST_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count == CW'($countones(r_queued)))
    `SST_ASSERT_IMP(a_no_accept_busy, i_clk, i_rst_n, r_state != S_IDLE, !s_axis_tready)
    `SST_ASSERT_NXT(a_div_done_idle, i_clk, i_rst_n, div_done, r_state == S_OUT)
endmodule

// ----- tb/stride_scheduler_table_tb.sv -----
// Self-checking testbench for the stride scheduler table with random stimulus and stalls.
`timescale 1ns / 1ps
module stride_scheduler_table_tb;
    import sst_pkg::*;

    localparam int NSLOT = 64;
    localparam longint CYCLE_LIMIT = 3000000;

    // The last field of the struct, command, sits in the lowest bits.
    typedef struct packed {
        logic [9:0]  slice_request;
        logic [31:0] task_priority;
        logic [5:0]  slot;
        logic [1:0]  command;
    } t_sched_cmd;

    typedef struct packed {
        logic       misuse;
        logic [6:0] queued_count;
        logic       resched;
        logic [5:0] picked_slot;
        logic       found;
    } t_sched_resp;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [9:0]  i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;

    stride_scheduler_table u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Shadow copy of the scheduler table.
    logic        sh_queued [NSLOT];
    logic [31:0] sh_stride [NSLOT];
    logic [31:0] sh_prio [NSLOT];
    logic [9:0]  sh_slice [NSLOT];
    logic [6:0]  sh_count;
    logic [9:0]  sh_max_slice;

    t_sched_cmd  pending_cmds[$];
    t_sched_resp expected_resps[$];
    int          fail_count = 0;
    int          resp_count = 0;
    int          pick_hits = 0;
    int          resched_hits = 0;
    int          misuse_hits = 0;
    longint      cycle_count = 0;
    int          send_gap = 0;
    int          recv_gap = 0;
    // Set at the rising edge at which the input transaction was accepted.
    logic        in_taken = 1'b0;

    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [31:0] stride_increment(input logic [31:0] p);
        if (p == 32'd0) return BIG_STEP;
        if (p > BIG_STEP) return 32'd1;
        return BIG_STEP / p;
    endfunction

    function automatic t_sched_resp predict_schedule(input t_sched_cmd c);
        t_sched_resp r;
        logic [31:0] d;
        logic [9:0]  req;
        r = '0;
        case (c.command)
            CMD_ENQ: begin
                if (sh_queued[c.slot]) begin
                    r.misuse = 1'b1;
                end else begin
                    req = c.slice_request;
                    if (req == 10'd0 || req > sh_max_slice) req = sh_max_slice;
                    sh_queued[c.slot] = 1'b1;
                    sh_prio[c.slot] = c.task_priority;
                    sh_slice[c.slot] = req;
                    sh_count = sh_count + 7'd1;
                end
            end
            CMD_DEQ: begin
                if (!sh_queued[c.slot]) begin
                    r.misuse = 1'b1;
                end else begin
                    sh_queued[c.slot] = 1'b0;
                    if (sh_count != 7'd0) sh_count = sh_count - 7'd1;
                end
            end
            CMD_PICK: begin
                for (int i = 0; i < NSLOT; i++) begin
                    d = sh_stride[i] - sh_stride[r.picked_slot];
                    if (sh_queued[i] && (!r.found || d[31])) begin
                        r.found = 1'b1;
                        r.picked_slot = 6'(i);
                    end
                end
                if (r.found)
                    sh_stride[r.picked_slot] += stride_increment(sh_prio[r.picked_slot]);
            end
            default: begin
                if (sh_slice[c.slot] != 10'd0) sh_slice[c.slot] -= 10'd1;
                r.resched = (sh_slice[c.slot] == 10'd0);
            end
        endcase
        r.queued_count = sh_count;
        return r;
    endfunction

    function automatic t_sched_cmd make_cmd(input logic [1:0] c, input logic [5:0] s,
                                            input logic [31:0] p, input logic [9:0] q);
        t_sched_cmd t;
        t.command = c;
        t.slot = s;
        t.task_priority = p;
        t.slice_request = q;
        return t;
    endfunction

    function automatic logic [31:0] rand_priority();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return $urandom_range(1, 8);
            2: return 32'h8000_0000 | $urandom;
            3: return BIG_STEP;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Driver: presents queued commands at the falling edge with random gaps and stalls the response side at random.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (s_axis_tvalid && !in_taken) begin
            s_axis_tvalid <= 1'b1;
        end else if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            s_axis_tvalid <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
            s_axis_tdata <= {6'd0, pending_cmds.pop_front()};
            s_axis_tvalid <= 1'b1;
            send_gap <= rand_gap();
        end else begin
            s_axis_tvalid <= 1'b0;
        end
        if (recv_gap > 0) begin
            m_axis_tready <= 1'b0;
            recv_gap <= recv_gap - 1;
        end else begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0) recv_gap <= rand_gap();
        end
    end

    // Monitor: predicts on accepted commands and checks every response transaction.
    always @(posedge i_clk) begin
        t_sched_resp act;
        t_sched_resp exp_r;
        cycle_count <= cycle_count + 1;
        in_taken <= i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            expected_resps.push_back(predict_schedule(t_sched_cmd'(s_axis_tdata[49:0])));
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            act = t_sched_resp'(m_axis_tdata);
            resp_count <= resp_count + 1;
            if (expected_resps.size() == 0) begin
                $error("response with no command outstanding: %h", m_axis_tdata);
                fail_count <= fail_count + 1;
            end else begin
                exp_r = expected_resps.pop_front();
                if (exp_r.found) pick_hits <= pick_hits + 1;
                if (exp_r.resched) resched_hits <= resched_hits + 1;
                if (exp_r.misuse) misuse_hits <= misuse_hits + 1;
                if (act.found !== exp_r.found)
                    $error("found: expected %0d actual %0d", exp_r.found, act.found);
                if (act.picked_slot !== exp_r.picked_slot)
                    $error("picked_slot: expected %0d actual %0d",
                           exp_r.picked_slot, act.picked_slot);
                if (act.resched !== exp_r.resched)
                    $error("resched: expected %0d actual %0d", exp_r.resched, act.resched);
                if (act.queued_count !== exp_r.queued_count)
                    $error("queued_count: expected %0d actual %0d",
                           exp_r.queued_count, act.queued_count);
                if (act.misuse !== exp_r.misuse)
                    $error("misuse: expected %0d actual %0d", exp_r.misuse, act.misuse);
                if (act !== exp_r) fail_count <= fail_count + 1;
            end
        end
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout with %0d responses outstanding", expected_resps.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic set_max_slice(input logic [9:0] v);
        while (pending_cmds.size() != 0 || s_axis_tvalid || expected_resps.size() != 0)
            @(posedge i_clk);
        // Give the block time to settle after the last response.
        repeat (20) @(negedge i_clk);
        i_cfg_wdata <= v;
        i_cfg_we <= 1'b1;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sh_max_slice = v;
    endtask

    task automatic queue_random_phase(input int n);
        int k;
        logic [5:0] s;
        for (k = 0; k < n; k++) begin
            s = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 11));
            case ($urandom_range(0, 9))
                0, 1, 2: pending_cmds.push_back(make_cmd(CMD_ENQ, s, rand_priority(),
                                                         10'($urandom)));
                3:       pending_cmds.push_back(make_cmd(CMD_DEQ, s, $urandom,
                                                         10'($urandom)));
                4, 5, 6: pending_cmds.push_back(make_cmd(CMD_PICK, s, $urandom,
                                                         10'($urandom)));
                default: pending_cmds.push_back(make_cmd(CMD_TICK, s, $urandom,
                                                         10'($urandom)));
            endcase
        end
    endtask

    initial begin
        logic [9:0] slice_settings [4];
        for (int i = 0; i < NSLOT; i++) begin
            sh_queued[i] = 1'b0;
            sh_stride[i] = '0;
            sh_prio[i] = '0;
            sh_slice[i] = '0;
        end
        sh_count = '0;
        sh_max_slice = MAX_SLICE_RST;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty pick, misuse cases, slice clamping, priority extremes, ties.
        pending_cmds.push_back(make_cmd(CMD_PICK, 6'd0, 32'd0, 10'd0));
        pending_cmds.push_back(make_cmd(CMD_DEQ, 6'd63, 32'd0, 10'd0));
        pending_cmds.push_back(make_cmd(CMD_TICK, 6'd5, 32'd0, 10'd0));
        pending_cmds.push_back(make_cmd(CMD_ENQ, 6'd63, 32'hFFFF_FFFF, 10'h3FF));
        pending_cmds.push_back(make_cmd(CMD_ENQ, 6'd63, 32'd1, 10'd1));
        pending_cmds.push_back(make_cmd(CMD_ENQ, 6'd0, 32'd0, 10'd0));
        pending_cmds.push_back(make_cmd(CMD_ENQ, 6'd1, BIG_STEP, 10'd3));
        pending_cmds.push_back(make_cmd(CMD_ENQ, 6'd2, 32'd1, 10'd5));
        pending_cmds.push_back(make_cmd(CMD_ENQ, 6'd42, 32'h8000_0000, 10'd2));
        for (int i = 0; i < 6; i++)
            pending_cmds.push_back(make_cmd(CMD_PICK, 6'd0, 32'd0, 10'd0));
        for (int i = 0; i < 4; i++)
            pending_cmds.push_back(make_cmd(CMD_TICK, 6'd1, 32'd0, 10'd0));
        pending_cmds.push_back(make_cmd(CMD_DEQ, 6'd2, 32'd0, 10'd0));
        pending_cmds.push_back(make_cmd(CMD_DEQ, 6'd2, 32'd0, 10'd0));
        pending_cmds.push_back(make_cmd(CMD_ENQ, 6'd2, 32'd3, 10'd0));
        pending_cmds.push_back(make_cmd(CMD_PICK, 6'd0, 32'd0, 10'd0));

        slice_settings[0] = 10'd1;
        slice_settings[1] = 10'h3FF;
        slice_settings[2] = 10'd0;
        slice_settings[3] = 10'($urandom_range(2, 40));
        queue_random_phase(290);
        for (int ph = 0; ph < 4; ph++) begin
            set_max_slice(slice_settings[ph]);
            queue_random_phase(290);
        end

        while (pending_cmds.size() != 0 || s_axis_tvalid || expected_resps.size() != 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("covered %0d responses: %0d picks found, %0d reschedules, %0d misuses",
                 resp_count, pick_hits, resched_hits, misuse_hits);
        $display("max_slice settings included 1, 1023, 0 and a mid value");
        if (fail_count == 0 && expected_resps.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
